/* rtl/msrc_pkg.sv */
package msrc_pkg;

  typedef enum logic [1:0] {
    REQ_CMD    = 2'd0,
    REQ_RAMP   = 2'd1,
    REQ_BLINK  = 2'd2,
    REQ_BUMPER = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    HEAD_FWD   = 2'd0,
    HEAD_LEFT  = 2'd1,
    HEAD_BACK  = 2'd2,
    HEAD_RIGHT = 2'd3
  } heading_e;

  localparam logic [7:0] CMD_FWD   = 8'h77; // 'w'
  localparam logic [7:0] CMD_LEFT  = 8'h61; // 'a'
  localparam logic [7:0] CMD_BACK  = 8'h73; // 's'
  localparam logic [7:0] CMD_RIGHT = 8'h64; // 'd'
  localparam logic [7:0] CMD_SPD1  = 8'h31; // '1'
  localparam logic [7:0] CMD_SPD2  = 8'h32; // '2'
  localparam logic [7:0] CMD_SPD3  = 8'h33; // '3'
  localparam logic [7:0] CMD_SPD0  = 8'h71; // 'q'
  localparam logic [7:0] CMD_STOP  = 8'h38; // '8'

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_THREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_START  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_DELAY = 3'd4;

  localparam logic [7:0] RST_SPEED_ONE   = 8'd50;
  localparam logic [7:0] RST_SPEED_TWO   = 8'd125;
  localparam logic [7:0] RST_SPEED_THREE = 8'd175;
  localparam logic [7:0] RST_RAMP_START  = 8'd10;
  localparam logic [4:0] RST_BLINK_DELAY = 5'd20;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] cmd_byte;
    logic       bumper_left;
    logic       bumper_right;
  } msrc_in_t;

  typedef struct packed {
    logic [7:0] pwm_duty;
    logic       dir_pin_a;
    logic       dir_pin_b;
    logic       blink_left_led;
    logic       blink_right_led;
    logic       ramping;
  } msrc_out_t;

endpackage

/* rtl/motor_speed_ramp_commander_top.sv */
// Two-motor drive controller. Each accepted event (command byte, ramp tick,
// blink tick or bumper sample) updates the speed, heading and blinker state
// and produces exactly one result in the next cycle, held in an output
// register. One event per clock is sustained while the output is not stalled,
// and input stall follows output stall only while a result is waiting.
// Configuration registers are written through a plain write port (index 0..4;
// other indexes are ignored); the user must write them only while no event is
// in flight, since the block itself does not enforce it.
module motor_speed_ramp_commander_top import msrc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  msrc_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output msrc_out_t             out_data_o
);

  logic [7:0] speed_one_q, speed_two_q, speed_three_q, ramp_start_q;
  logic [4:0] blink_delay_q;

  logic [7:0] speed_now_q, speed_now_d;
  logic [7:0] speed_goal_q, speed_goal_d;
  logic       pending_q, pending_d;
  heading_e   heading_q, heading_d;
  logic [4:0] blink_cnt_q, blink_cnt_d;
  logic       left_led_q, left_led_d;
  logic       right_led_q, right_led_d;

  logic       out_valid_q;
  msrc_out_t  out_q, out_d;
  logic       accept;

  logic       head_req, goal_req;
  heading_e   head_new;
  logic [7:0] goal_new;
  logic [7:0] ramp_base;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_one_q   <= RST_SPEED_ONE;
      speed_two_q   <= RST_SPEED_TWO;
      speed_three_q <= RST_SPEED_THREE;
      ramp_start_q  <= RST_RAMP_START;
      blink_delay_q <= RST_BLINK_DELAY;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SPEED_ONE:   speed_one_q   <= cfg_data_i;
        CFG_SPEED_TWO:   speed_two_q   <= cfg_data_i;
        CFG_SPEED_THREE: speed_three_q <= cfg_data_i;
        CFG_RAMP_START:  ramp_start_q  <= cfg_data_i;
        CFG_BLINK_DELAY: blink_delay_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    speed_now_d  = speed_now_q;
    speed_goal_d = speed_goal_q;
    pending_d    = pending_q;
    heading_d    = heading_q;
    blink_cnt_d  = blink_cnt_q;
    left_led_d   = left_led_q;
    right_led_d  = right_led_q;
    head_req     = 1'b0;
    goal_req     = 1'b0;
    head_new     = HEAD_FWD;
    goal_new     = '0;
    ramp_base    = (speed_now_q == 8'd0) ? ramp_start_q : speed_now_q;

    case (req_type_e'(in_data_i.req_type))
      REQ_CMD: begin
        case (in_data_i.cmd_byte)
          CMD_FWD:   begin head_req = 1'b1; head_new = HEAD_FWD;   end
          CMD_LEFT:  begin head_req = 1'b1; head_new = HEAD_LEFT;  end
          CMD_BACK:  begin head_req = 1'b1; head_new = HEAD_BACK;  end
          CMD_RIGHT: begin head_req = 1'b1; head_new = HEAD_RIGHT; end
          CMD_SPD1:  begin goal_req = 1'b1; goal_new = speed_one_q;   end
          CMD_SPD2:  begin goal_req = 1'b1; goal_new = speed_two_q;   end
          CMD_SPD3:  begin goal_req = 1'b1; goal_new = speed_three_q; end
          CMD_SPD0:  begin goal_req = 1'b1; goal_new = 8'd0;          end
          CMD_STOP: begin
            speed_now_d  = 8'd0;
            speed_goal_d = 8'd0;
          end
          default: ;
        endcase
      end
      REQ_RAMP: begin
        if (pending_q && speed_now_q != speed_goal_q) begin
          if (speed_now_q > speed_goal_q) begin
            speed_now_d = speed_now_q - 8'd1;
          end else if (ramp_base != 8'hFF) begin
            speed_now_d = ramp_base + 8'd1;
          end else begin
            speed_now_d = ramp_base;
          end
        end
        if (pending_q) begin
          pending_d = (speed_now_d != speed_goal_q);
        end
      end
      REQ_BLINK: begin
        if (blink_cnt_q != 5'd31) begin
          blink_cnt_d = blink_cnt_q + 5'd1;
        end
        if (blink_cnt_d > blink_delay_q) begin
          case (heading_q)
            HEAD_LEFT: begin
              left_led_d  = ~left_led_q;
              right_led_d = 1'b0;
            end
            HEAD_RIGHT: begin
              left_led_d  = 1'b0;
              right_led_d = ~right_led_q;
            end
            default: begin
              left_led_d  = 1'b0;
              right_led_d = 1'b0;
            end
          endcase
        end
      end
      REQ_BUMPER: begin
        if (in_data_i.bumper_right) begin
          head_req = 1'b1;
          head_new = HEAD_LEFT;
          goal_req = 1'b1;
          goal_new = speed_one_q;
        end else if (in_data_i.bumper_left) begin
          head_req = 1'b1;
          head_new = HEAD_RIGHT;
          goal_req = 1'b1;
          goal_new = speed_one_q;
        end
      end
      default: ;
    endcase

    if (head_req && head_new != heading_q) begin
      heading_d   = head_new;
      blink_cnt_d = blink_delay_q;
    end
    if (goal_req && goal_new != speed_goal_q) begin
      speed_goal_d = goal_new;
      pending_d    = 1'b1;
    end

    out_d.pwm_duty        = speed_now_d;
    out_d.dir_pin_a       = (heading_d == HEAD_LEFT) || (heading_d == HEAD_BACK);
    out_d.dir_pin_b       = (heading_d == HEAD_RIGHT) || (heading_d == HEAD_BACK);
    out_d.blink_left_led  = left_led_d;
    out_d.blink_right_led = right_led_d;
    out_d.ramping         = pending_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_now_q  <= '0;
      speed_goal_q <= '0;
      pending_q    <= 1'b0;
      heading_q    <= HEAD_FWD;
      blink_cnt_q  <= '0;
      left_led_q   <= 1'b0;
      right_led_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        speed_now_q  <= speed_now_d;
        speed_goal_q <= speed_goal_d;
        pending_q    <= pending_d;
        heading_q    <= heading_d;
        blink_cnt_q  <= blink_cnt_d;
        left_led_q   <= left_led_d;
        right_led_q  <= right_led_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

endmodule

/* test/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import msrc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  msrc_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  msrc_out_t             out_data;

  motor_speed_ramp_commander_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #5 clk = ~clk;

  // drive controller prediction state
  logic [7:0] lvl_one, lvl_two, lvl_three, start_duty;
  logic [4:0] blink_dly;
  logic [7:0] cur_speed, goal_speed;
  logic       ramp_busy;
  heading_e   head_now;
  logic [4:0] blink_cnt;
  logic       led_l, led_r;

  msrc_out_t  expected_drive[$];
  int         fail_count = 0;
  bit         calm = 1'b0;
  int         stall_left = 0;

  function automatic void reset_drive_model();
    lvl_one    = RST_SPEED_ONE;
    lvl_two    = RST_SPEED_TWO;
    lvl_three  = RST_SPEED_THREE;
    start_duty = RST_RAMP_START;
    blink_dly  = RST_BLINK_DELAY;
    cur_speed  = '0;
    goal_speed = '0;
    ramp_busy  = 1'b0;
    head_now   = HEAD_FWD;
    blink_cnt  = '0;
    led_l      = 1'b0;
    led_r      = 1'b0;
  endfunction

  function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    case (idx)
      CFG_SPEED_ONE:   lvl_one    = val;
      CFG_SPEED_TWO:   lvl_two    = val;
      CFG_SPEED_THREE: lvl_three  = val;
      CFG_RAMP_START:  start_duty = val;
      CFG_BLINK_DELAY: blink_dly  = val[4:0];
      default: ;
    endcase
  endfunction

  function automatic void steer_to(heading_e h);
    if (h != head_now) begin
      head_now  = h;
      blink_cnt = blink_dly;
    end
  endfunction

  function automatic void aim_speed(logic [7:0] g);
    if (g != goal_speed) begin
      goal_speed = g;
      ramp_busy  = 1'b1;
    end
  endfunction

  function automatic msrc_out_t drive_step(msrc_in_t ev);
    msrc_out_t res;
    case (req_type_e'(ev.req_type))
      REQ_CMD: begin
        case (ev.cmd_byte)
          CMD_FWD:   steer_to(HEAD_FWD);
          CMD_LEFT:  steer_to(HEAD_LEFT);
          CMD_BACK:  steer_to(HEAD_BACK);
          CMD_RIGHT: steer_to(HEAD_RIGHT);
          CMD_SPD1:  aim_speed(lvl_one);
          CMD_SPD2:  aim_speed(lvl_two);
          CMD_SPD3:  aim_speed(lvl_three);
          CMD_SPD0:  aim_speed(8'd0);
          CMD_STOP: begin
            goal_speed = '0;
            cur_speed  = '0;
          end
          default: ;
        endcase
      end
      REQ_RAMP: begin
        if (ramp_busy) begin
          if (cur_speed == goal_speed) begin
            ramp_busy = 1'b0;
          end else begin
            if (cur_speed > goal_speed) begin
              cur_speed = cur_speed - 8'd1;
            end else begin
              if (cur_speed == 8'd0) cur_speed = start_duty;
              if (cur_speed < 8'hFF) cur_speed = cur_speed + 8'd1;
            end
            if (cur_speed == goal_speed) ramp_busy = 1'b0;
          end
        end
      end
      REQ_BLINK: begin
        if (blink_cnt < 5'd31) blink_cnt = blink_cnt + 5'd1;
        if (blink_cnt > blink_dly) begin
          case (head_now)
            HEAD_LEFT: begin
              led_l = ~led_l;
              led_r = 1'b0;
            end
            HEAD_RIGHT: begin
              led_l = 1'b0;
              led_r = ~led_r;
            end
            default: begin
              led_l = 1'b0;
              led_r = 1'b0;
            end
          endcase
        end
      end
      default: begin
        if (ev.bumper_right) begin
          steer_to(HEAD_LEFT);
          aim_speed(lvl_one);
        end else if (ev.bumper_left) begin
          steer_to(HEAD_RIGHT);
          aim_speed(lvl_one);
        end
      end
    endcase
    res.pwm_duty        = cur_speed;
    res.dir_pin_a       = (head_now == HEAD_LEFT) || (head_now == HEAD_BACK);
    res.dir_pin_b       = (head_now == HEAD_RIGHT) || (head_now == HEAD_BACK);
    res.blink_left_led  = led_l;
    res.blink_right_led = led_r;
    res.ramping         = ramp_busy;
    return res;
  endfunction

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic msrc_in_t cmd(logic [7:0] c);
    msrc_in_t ev;
    ev          = '0;
    ev.req_type = REQ_CMD;
    ev.cmd_byte = c;
    return ev;
  endfunction

  function automatic msrc_in_t tick(req_type_e t);
    msrc_in_t ev;
    ev          = '0;
    ev.req_type = t;
    return ev;
  endfunction

  function automatic msrc_in_t bumper(logic l, logic r);
    msrc_in_t ev;
    ev              = '0;
    ev.req_type     = REQ_BUMPER;
    ev.bumper_left  = l;
    ev.bumper_right = r;
    return ev;
  endfunction

  function automatic logic [7:0] pick_cmd();
    case ($urandom_range(0, 8))
      0:       return CMD_FWD;
      1:       return CMD_LEFT;
      2:       return CMD_BACK;
      3:       return CMD_RIGHT;
      4:       return CMD_SPD1;
      5:       return CMD_SPD2;
      6:       return CMD_SPD3;
      7:       return CMD_SPD0;
      default: return CMD_STOP;
    endcase
  endfunction

  function automatic msrc_in_t random_event();
    msrc_in_t    ev;
    logic [31:0] bits;
    int          roll;
    bits = $urandom;
    ev   = bits[$bits(msrc_in_t)-1:0];
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      ev.req_type = REQ_CMD;
      ev.cmd_byte = pick_cmd();
    end else if (roll < 40) begin
      ev.req_type = REQ_CMD;
    end else if (roll < 68) begin
      ev.req_type = REQ_RAMP;
    end else if (roll < 85) begin
      ev.req_type = REQ_BLINK;
    end else begin
      ev.req_type = REQ_BUMPER;
    end
    return ev;
  endfunction

  task automatic send_event(input msrc_in_t ev);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_drive.push_back(drive_step(ev));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(logic [7:0] one, logic [7:0] two, logic [7:0] three,
                              logic [7:0] start, logic [4:0] dly);
    logic [7:0]           vals[5];
    logic [CFG_IDX_W-1:0] idxs[5];
    logic [2:0]           junk;
    logic [7:0]           noise;
    junk  = 3'($urandom);
    noise = 8'($urandom);
    vals  = '{one, two, three, start, {junk, dly}};
    idxs  = '{CFG_SPEED_ONE, CFG_SPEED_TWO, CFG_SPEED_THREE, CFG_RAMP_START,
              CFG_BLINK_DELAY};
    for (int i = 0; i < 5; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idxs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      store_reg(idxs[i], vals[i]);
    end
    // out-of-range index, must be ignored
    cfg_idx  <= CFG_IDX_W'($urandom_range(5, 7));
    cfg_data <= noise;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // result checker and output stall generator
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_drive.size() == 0) begin
          $error("unexpected result transfer: %h", out_data);
          fail_count++;
        end else begin
          msrc_out_t want;
          want = expected_drive.pop_front();
          check_field("pwm_duty", want.pwm_duty, out_data.pwm_duty);
          check_field("dir_pin_a", 8'(want.dir_pin_a), 8'(out_data.dir_pin_a));
          check_field("dir_pin_b", 8'(want.dir_pin_b), 8'(out_data.dir_pin_b));
          check_field("blink_left_led", 8'(want.blink_left_led),
                      8'(out_data.blink_left_led));
          check_field("blink_right_led", 8'(want.blink_right_led),
                      8'(out_data.blink_right_led));
          check_field("ramping", 8'(want.ramping), 8'(out_data.ramping));
        end
        stall_left = draw_wait();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_basic_commands();
    send_event(tick(REQ_RAMP));        // nothing pending
    send_event(tick(REQ_BLINK));
    send_event(cmd(CMD_FWD));          // same heading again
    send_event(cmd(CMD_LEFT));
    send_event(tick(REQ_BLINK));
    send_event(cmd(CMD_RIGHT));
    send_event(tick(REQ_BLINK));
    send_event(cmd(CMD_SPD1));
    send_event(tick(REQ_RAMP));        // jump from zero to one above start duty
    send_event(cmd(CMD_STOP));         // hard stop keeps ramping flag
    send_event(tick(REQ_RAMP));        // already at target
    send_event(cmd(CMD_SPD1));
    send_event(cmd(CMD_SPD1));
    send_event(cmd(CMD_BACK));
    send_event(tick(REQ_BLINK));
    send_event(cmd(CMD_SPD2));
    send_event(cmd(CMD_SPD3));
    send_event(cmd(CMD_SPD0));
    send_event(cmd(8'h00));
    send_event(cmd(8'hFF));
    send_event(bumper(1'b0, 1'b1));
    send_event(bumper(1'b1, 1'b0));
    send_event(bumper(1'b1, 1'b1));
    send_event(bumper(1'b0, 1'b0));
  endtask

  task automatic test_ramp_limits();
    wait_drained();
    apply_config(8'd20, 8'd0, 8'd255, 8'd255, 5'd31);
    send_event(cmd(CMD_STOP));
    send_event(cmd(CMD_SPD1));
    send_event(tick(REQ_RAMP));        // jump saturates at full duty, past target
    send_event(tick(REQ_RAMP));
    send_event(cmd(CMD_SPD3));
    send_event(tick(REQ_RAMP));
    send_event(tick(REQ_BLINK));       // max delay never blinks
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        0: apply_config(RST_SPEED_ONE, RST_SPEED_TWO, RST_SPEED_THREE,
                        RST_RAMP_START, RST_BLINK_DELAY);
        1: apply_config(8'd0, 8'd0, 8'd0, 8'd0, 5'd0);
        2: apply_config(8'd255, 8'd255, 8'd255, 8'd255, 5'd31);
        3: apply_config(8'd20, 8'd40, 8'd60, 8'd200, 5'd2);
        default: apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              5'($urandom_range(0, 31)));
      endcase
      for (int n = 0; n < 230; n++) begin
        if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        if (n == 115) wait_drained();
        send_event(random_event());
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("motor_speed_ramp_commander_top verification failed");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    reset_drive_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_commands();
    test_ramp_limits();
    test_random_traffic();

    in_valid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("motor_speed_ramp_commander_top verification clean");
    end else begin
      $display("motor_speed_ramp_commander_top verification failed");
    end
    $finish;
  end

endmodule
